[rtl/core/generation_stamped_hash_set_assert.svh]
// assertion macros for the hash set rtl, included by the controller
`ifndef GENERATION_STAMPED_HASH_SET_ASSERT_SVH
`define GENERATION_STAMPED_HASH_SET_ASSERT_SVH

// same-cycle implication
`define GSHS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gshs assertion failed");

// next-cycle implication
`define GSHS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gshs assertion failed");

// invariant
`define GSHS_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("gshs assertion failed");

`endif

[rtl/core/gshs_pkg.sv]
`timescale 1ns / 1ps

package gshs_pkg;

   localparam int LOG_SLOTS  = 10;
   localparam int STAMP_BITS = 16;
   localparam int KEY_BITS   = 64;
   localparam int ENTRY_BITS = KEY_BITS + STAMP_BITS;

   localparam logic [63:0] HASH_ADD   = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] HASH_MUL_A = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] HASH_MUL_B = 64'h94d049bb133111eb;

   typedef logic [LOG_SLOTS-1:0]  slot_type;
   typedef logic [STAMP_BITS-1:0] stamp_type;
   typedef logic [KEY_BITS-1:0]   key_type;
   typedef logic [ENTRY_BITS-1:0] entry_type;

   localparam slot_type SLOT_LAST = '1;

   typedef enum logic [1:0] {
      OUT_INSERTED = 2'd0,
      OUT_PRESENT  = 2'd1,
      OUT_FULL     = 2'd2,
      OUT_CLEARED  = 2'd3
   } outcome_type;

   localparam logic OP_TEST  = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   // table access from the probe controller
   typedef struct packed {
      logic      we;
      slot_type  waddr;
      entry_type wdata;
      slot_type  raddr;
   } mem_req_type;

endpackage

[rtl/core/gshs_req_if.sv]
`timescale 1ns / 1ps

interface gshs_req_if;
   logic                           valid;
   logic                           ready;
   logic                           op;
   logic [gshs_pkg::KEY_BITS-1:0]  search_key;

   modport source (output valid, output op, output search_key, input ready);
   modport sink (input valid, input op, input search_key, output ready);
endinterface

[rtl/core/gshs_rsp_if.sv]
`timescale 1ns / 1ps

interface gshs_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] outcome;

   modport source (output valid, output outcome, input ready);
   modport sink (input valid, input outcome, output ready);
endinterface

[rtl/core/gshs_ram.sv]
`timescale 1ns / 1ps

module gshs_ram #(
   parameter int ADDR_BITS = 10,
   parameter int DATA_BITS = 80
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [ADDR_BITS-1:0] waddr,
   input  logic [DATA_BITS-1:0] wdata,
   input  logic [ADDR_BITS-1:0] raddr,
   output logic [DATA_BITS-1:0] rdata
);

   logic [DATA_BITS-1:0] mem [2**ADDR_BITS];
   logic [DATA_BITS-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/core/gshs_hash.sv]
`timescale 1ns / 1ps

module gshs_hash (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  gshs_pkg::key_type  key,
   output logic               done,
   output gshs_pkg::slot_type home
);

   logic [4:0] valid_ff, valid_in;

   logic [63:0] a_ff, a_in;
   logic [63:0] lo1_ff, lo1_in;
   logic [31:0] xa1_ff, xa1_in, xb1_ff, xb1_in;
   logic [63:0] b_ff, b_in;
   logic [63:0] lo2_ff, lo2_in;
   logic [31:0] xa2_ff, xa2_in, xb2_ff, xb2_in;
   gshs_pkg::slot_type home_ff, home_in;

   logic [63:0] v0, m1, m2, h;

   always_comb begin
      // add and first xor-shift
      v0 = key + gshs_pkg::HASH_ADD;
      a_in = v0 ^ (v0 >> 30);

      // first multiply as 32x32 partial products, low 64 bits only
      lo1_in = a_ff[31:0] * gshs_pkg::HASH_MUL_A[31:0];
      xa1_in = a_ff[31:0] * gshs_pkg::HASH_MUL_A[63:32];
      xb1_in = a_ff[63:32] * gshs_pkg::HASH_MUL_A[31:0];

      m1 = lo1_ff + {xa1_ff + xb1_ff, 32'b0};
      b_in = m1 ^ (m1 >> 27);

      // second multiply
      lo2_in = b_ff[31:0] * gshs_pkg::HASH_MUL_B[31:0];
      xa2_in = b_ff[31:0] * gshs_pkg::HASH_MUL_B[63:32];
      xb2_in = b_ff[63:32] * gshs_pkg::HASH_MUL_B[31:0];

      m2 = lo2_ff + {xa2_ff + xb2_ff, 32'b0};
      h = m2 ^ (m2 >> 31);
      home_in = h[gshs_pkg::LOG_SLOTS-1:0];

      valid_in = {valid_ff[3:0], start};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      a_ff    <= a_in;
      lo1_ff  <= lo1_in;
      xa1_ff  <= xa1_in;
      xb1_ff  <= xb1_in;
      b_ff    <= b_in;
      lo2_ff  <= lo2_in;
      xa2_ff  <= xa2_in;
      xb2_ff  <= xb2_in;
      home_ff <= home_in;
   end

   assign done = valid_ff[4];
   assign home = home_ff;

endmodule

[rtl/core/gshs_ctrl.sv]
`timescale 1ns / 1ps

`include "generation_stamped_hash_set_assert.svh"

module gshs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   gshs_req_if.sink              req_chan,
   gshs_rsp_if.source            rsp_chan,
   output logic                  hash_start,
   input  logic                  hash_done,
   input  gshs_pkg::slot_type    hash_home,
   output gshs_pkg::mem_req_type mem_req,
   input  gshs_pkg::entry_type   mem_rdata
);

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_HASH    = 5'b00010,
      ST_COMPARE = 5'b00100,
      ST_WIPE    = 5'b01000,
      ST_DONE    = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   gshs_pkg::stamp_type    gen_ff, gen_in;
   gshs_pkg::key_type      key_ff, key_in;
   gshs_pkg::slot_type     home_ff, home_in;
   gshs_pkg::slot_type     pos_ff, pos_in;
   gshs_pkg::slot_type     wipe_cnt_ff, wipe_cnt_in;
   logic                   wipe_report_ff, wipe_report_in;
   gshs_pkg::outcome_type  res_ff, res_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   gshs_pkg::outcome_type  outcome_ff, outcome_in;

   logic                   req_fire;
   logic                   out_free;
   logic                   finish;
   logic                   out_load;
   gshs_pkg::outcome_type  fin_code;
   gshs_pkg::stamp_type    gen_next;
   gshs_pkg::stamp_type    rd_stamp;
   gshs_pkg::key_type      rd_key;
   gshs_pkg::slot_type     pos_next;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign gen_next = gen_ff + gshs_pkg::stamp_type'(1);
   assign pos_next = pos_ff + gshs_pkg::slot_type'(1);
   assign rd_stamp = mem_rdata[gshs_pkg::STAMP_BITS-1:0];
   assign rd_key   = mem_rdata[gshs_pkg::ENTRY_BITS-1:gshs_pkg::STAMP_BITS];

   always_comb begin
      state_in       = state_ff;
      gen_in         = gen_ff;
      key_in         = key_ff;
      home_in        = home_ff;
      pos_in         = pos_ff;
      wipe_cnt_in    = wipe_cnt_ff;
      wipe_report_in = wipe_report_ff;
      res_in         = res_ff;
      hash_start     = 1'b0;
      finish         = 1'b0;
      fin_code       = res_ff;
      mem_req.we     = 1'b0;
      mem_req.waddr  = pos_ff;
      mem_req.wdata  = {key_ff, gen_ff};
      mem_req.raddr  = pos_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_chan.op == gshs_pkg::OP_CLEAR) begin
                  if (gen_next == '0) begin
                     // generation wrap: sweep all stamps back to zero
                     gen_in         = gshs_pkg::stamp_type'(1);
                     wipe_cnt_in    = '0;
                     wipe_report_in = 1'b1;
                     state_in       = ST_WIPE;
                  end else begin
                     gen_in   = gen_next;
                     res_in   = gshs_pkg::OUT_CLEARED;
                     state_in = ST_DONE;
                  end
               end else begin
                  key_in     = req_chan.search_key;
                  hash_start = 1'b1;
                  state_in   = ST_HASH;
               end
            end
         end
         ST_HASH: begin
            if (hash_done) begin
               home_in       = hash_home;
               pos_in        = hash_home;
               mem_req.raddr = hash_home;
               state_in      = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            if (rd_stamp != gen_ff) begin
               mem_req.we = 1'b1;
               finish     = 1'b1;
               fin_code   = gshs_pkg::OUT_INSERTED;
            end else if (rd_key == key_ff) begin
               finish   = 1'b1;
               fin_code = gshs_pkg::OUT_PRESENT;
            end else if (pos_next == home_ff) begin
               finish   = 1'b1;
               fin_code = gshs_pkg::OUT_FULL;
            end else begin
               pos_in        = pos_next;
               mem_req.raddr = pos_next;
            end
         end
         ST_WIPE: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = wipe_cnt_ff;
            mem_req.wdata = '0;
            wipe_cnt_in   = wipe_cnt_ff + gshs_pkg::slot_type'(1);
            if (wipe_cnt_ff == gshs_pkg::SLOT_LAST) begin
               if (wipe_report_ff) begin
                  finish   = 1'b1;
                  fin_code = gshs_pkg::OUT_CLEARED;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DONE: begin
            finish = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      out_load = finish && out_free;
      if (finish) begin
         res_in   = fin_code;
         state_in = out_free ? ST_IDLE : ST_DONE;
      end

      rsp_valid_in = rsp_valid_ff;
      outcome_in   = outcome_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         outcome_in   = fin_code;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_WIPE;
         gen_ff         <= gshs_pkg::stamp_type'(1);
         wipe_cnt_ff    <= '0;
         wipe_report_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         gen_ff         <= gen_in;
         wipe_cnt_ff    <= wipe_cnt_in;
         wipe_report_ff <= wipe_report_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      key_ff     <= key_in;
      home_ff    <= home_in;
      pos_ff     <= pos_in;
      res_ff     <= res_in;
      outcome_ff <= outcome_in;
   end

   assign req_chan.ready   = (state_ff == ST_IDLE);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.outcome = outcome_ff;

   `GSHS_ASSERT_ALWAYS(gen_nonzero_a, clock, reset, gen_ff != '0)
   `GSHS_ASSERT_IMPLIES(hash_in_hash_state_a, clock, reset, hash_done, state_ff == ST_HASH)
   `GSHS_ASSERT_IMPLIES(write_state_a, clock, reset, mem_req.we,
      (state_ff == ST_COMPARE) || (state_ff == ST_WIPE))
   `GSHS_ASSERT_NEXT(wrap_wipes_a, clock, reset,
      req_fire && (req_chan.op == gshs_pkg::OP_CLEAR) && (gen_ff == '1),
      (state_ff == ST_WIPE) && (gen_ff == gshs_pkg::stamp_type'(1)))

endmodule

[rtl/core/generation_stamped_hash_set.sv]
// test transaction: key hashed by the 5-stage hash pipeline, then one table read per
// slot probed, then the outcome goes to the result register; the next transaction is
// accepted only after the result register has taken the outcome
// clear transaction: no table access unless the generation wraps
// generation wrap and reset each sweep all 1024 table slots; req_chan.ready low
// synchronous active-high reset; generation restarts at 1, result register empty
`timescale 1ns / 1ps

module generation_stamped_hash_set (
   input  logic       clock,
   input  logic       reset,
   gshs_req_if.sink   req_chan,
   gshs_rsp_if.source rsp_chan
);

   logic                  hash_start;
   logic                  hash_done;
   gshs_pkg::slot_type    hash_home;
   gshs_pkg::mem_req_type mem_req;
   gshs_pkg::entry_type   mem_rdata;

   gshs_hash u_hash (
      .clock (clock),
      .reset (reset),
      .start (hash_start),
      .key   (req_chan.search_key),
      .done  (hash_done),
      .home  (hash_home)
   );

   gshs_ram #(
      .ADDR_BITS (gshs_pkg::LOG_SLOTS),
      .DATA_BITS (gshs_pkg::ENTRY_BITS)
   ) u_table (
      .clock (clock),
      .we    (mem_req.we),
      .waddr (mem_req.waddr),
      .wdata (mem_req.wdata),
      .raddr (mem_req.raddr),
      .rdata (mem_rdata)
   );

   gshs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .hash_start (hash_start),
      .hash_done  (hash_done),
      .hash_home  (hash_home),
      .mem_req    (mem_req),
      .mem_rdata  (mem_rdata)
   );

endmodule

[verif/gshs_membership_checker.sv]
`timescale 1ns / 1ps

module gshs_membership_checker (
   input  logic clock,
   input  logic reset,
   gshs_req_if  req_mon,
   gshs_rsp_if  rsp_mon,
   output int   fail_count,
   output int   expected_left,
   output int   inserted_seen,
   output int   present_seen,
   output int   full_seen,
   output int   cleared_seen
);

   localparam int SLOT_COUNT = 1 << gshs_pkg::LOG_SLOTS;

   gshs_pkg::key_type     shadow_keys [SLOT_COUNT];
   gshs_pkg::stamp_type   shadow_stamps [SLOT_COUNT];
   gshs_pkg::stamp_type   shadow_generation;
   gshs_pkg::outcome_type pending_outcomes [$];

   function automatic gshs_pkg::key_type splitmix_home(input gshs_pkg::key_type v);
      gshs_pkg::key_type x;
      x = v + gshs_pkg::HASH_ADD;
      x = (x ^ (x >> 30)) * gshs_pkg::HASH_MUL_A;
      x = (x ^ (x >> 27)) * gshs_pkg::HASH_MUL_B;
      return x ^ (x >> 31);
   endfunction

   function automatic gshs_pkg::outcome_type predict_membership(input gshs_pkg::key_type k);
      gshs_pkg::slot_type pos;
      pos = gshs_pkg::slot_type'(splitmix_home(k));
      for (int n = 0; n < SLOT_COUNT; n++) begin
         if (shadow_stamps[pos] != shadow_generation) begin
            shadow_stamps[pos] = shadow_generation;
            shadow_keys[pos]   = k;
            return gshs_pkg::OUT_INSERTED;
         end
         if (shadow_keys[pos] == k) return gshs_pkg::OUT_PRESENT;
         pos = pos + gshs_pkg::slot_type'(1);
      end
      return gshs_pkg::OUT_FULL;
   endfunction

   // wrap to zero wipes every stamp and restarts at one
   function automatic void start_generation();
      shadow_generation = shadow_generation + gshs_pkg::stamp_type'(1);
      if (shadow_generation == '0) begin
         foreach (shadow_stamps[i]) shadow_stamps[i] = '0;
         shadow_generation = gshs_pkg::stamp_type'(1);
      end
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      fail_count++;
   endtask

   always @(posedge clock) begin
      gshs_pkg::outcome_type want;
      if (reset) begin
         foreach (shadow_stamps[i]) shadow_stamps[i] = '0;
         shadow_generation = gshs_pkg::stamp_type'(1);
         pending_outcomes.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.op == gshs_pkg::OP_CLEAR) begin
               start_generation();
               pending_outcomes.push_back(gshs_pkg::OUT_CLEARED);
            end else begin
               pending_outcomes.push_back(predict_membership(req_mon.search_key));
            end
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            case (rsp_mon.outcome)
               gshs_pkg::OUT_INSERTED: inserted_seen++;
               gshs_pkg::OUT_PRESENT:  present_seen++;
               gshs_pkg::OUT_FULL:     full_seen++;
               gshs_pkg::OUT_CLEARED:  cleared_seen++;
               default: ;
            endcase
            if (pending_outcomes.size() == 0) begin
               report_mismatch($sformatf("outcome %0d with no transaction outstanding",
                                         rsp_mon.outcome));
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_mon.outcome !== want) begin
                  report_mismatch($sformatf("outcome %0d, predicted %0d (%s)",
                                            rsp_mon.outcome, want, want.name()));
               end
            end
         end
      end
      expected_left <= pending_outcomes.size();
   end

endmodule

[verif/generation_stamped_hash_set_tb.sv]
`timescale 1ns / 1ps

module generation_stamped_hash_set_tb;

   localparam int SLOT_COUNT     = 1 << gshs_pkg::LOG_SLOTS;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 1100;
   localparam int PHASE_ITEMS    = 55;

   logic clock = 1'b0;
   logic reset = 1'b1;

   gshs_req_if req_chan ();
   gshs_rsp_if rsp_chan ();

   int                send_idle_pct = 0;
   int                recv_idle_pct = 0;
   int                quiet_cycles  = 0;
   int                items_sent    = 0;
   int                clears_sent   = 0;
   gshs_pkg::key_type recent_keys [$];

   int fail_count, expected_left;
   int inserted_seen, present_seen, full_seen, cleared_seen;

   generation_stamped_hash_set DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   gshs_membership_checker membership_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .fail_count    (fail_count),
      .expected_left (expected_left),
      .inserted_seen (inserted_seen),
      .present_seen  (present_seen),
      .full_seen     (full_seen),
      .cleared_seen  (cleared_seen)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      rsp_chan.ready <= !reset && ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: %0d cycles without a transaction", quiet_cycles);
            $display("[generation_stamped_hash_set] ERROR");
            $finish;
         end
      end
   end

   function automatic gshs_pkg::key_type random_key();
      return {32'($urandom()), 32'($urandom())};
   endfunction

   task automatic send_item(input logic op_i, input gshs_pkg::key_type key_i);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(0, 99) < send_idle_pct) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.op         <= op_i;
      req_chan.search_key <= key_i;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      items_sent++;
      if (op_i == gshs_pkg::OP_CLEAR) begin
         clears_sent++;
      end
   endtask

   task automatic run_random(input int count);
      int                pick;
      gshs_pkg::key_type k;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            send_item(gshs_pkg::OP_CLEAR, random_key());
         end else if (pick < 46 && recent_keys.size() > 0) begin
            send_item(gshs_pkg::OP_TEST,
                      recent_keys[$urandom_range(0, recent_keys.size() - 1)]);
         end else if (pick < 50) begin
            send_item(gshs_pkg::OP_TEST, $urandom_range(0, 1) ? '0 : '1);
         end else begin
            k = random_key();
            recent_keys.push_back(k);
            if (recent_keys.size() > 64) void'(recent_keys.pop_front());
            send_item(gshs_pkg::OP_TEST, k);
         end
      end
   endtask

   // distinct upper halves guarantee every slot ends up taken
   task automatic fill_table();
      logic [31:0]       base;
      gshs_pkg::key_type first_key;
      send_item(gshs_pkg::OP_CLEAR, random_key());
      base      = $urandom();
      first_key = {base, 32'($urandom())};
      send_item(gshs_pkg::OP_TEST, first_key);
      for (int i = 1; i < SLOT_COUNT; i++) begin
         send_item(gshs_pkg::OP_TEST, {base ^ 32'(i), 32'($urandom())});
      end
      repeat (3) send_item(gshs_pkg::OP_TEST, random_key());
      send_item(gshs_pkg::OP_TEST, first_key);
      send_item(gshs_pkg::OP_CLEAR, random_key());
      send_item(gshs_pkg::OP_TEST, first_key);
   endtask

   initial begin
      req_chan.valid      = 1'b0;
      req_chan.op         = gshs_pkg::OP_TEST;
      req_chan.search_key = '0;
      rsp_chan.ready      = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 27;
      recv_idle_pct = 65;
      send_item(gshs_pkg::OP_TEST, '0);
      send_item(gshs_pkg::OP_TEST, '0);
      send_item(gshs_pkg::OP_TEST, '1);
      send_item(gshs_pkg::OP_TEST, '1);
      send_item(gshs_pkg::OP_TEST, 64'h8000_0000_0000_0000);
      send_item(gshs_pkg::OP_TEST, 64'h0000_0000_0000_0001);
      send_item(gshs_pkg::OP_TEST, 64'hAAAA_AAAA_AAAA_AAAA);
      send_item(gshs_pkg::OP_TEST, 64'h5555_5555_5555_5555);
      send_item(gshs_pkg::OP_TEST, 64'd0 - gshs_pkg::HASH_ADD);
      send_item(gshs_pkg::OP_TEST, '0);
      send_item(gshs_pkg::OP_CLEAR, '1);
      send_item(gshs_pkg::OP_TEST, '0);
      send_item(gshs_pkg::OP_TEST, '1);
      send_item(gshs_pkg::OP_CLEAR, '0);
      send_item(gshs_pkg::OP_CLEAR, random_key());
      send_item(gshs_pkg::OP_TEST, '1);
      send_item(gshs_pkg::OP_TEST, 64'h8000_0000_0000_0000);
      run_random(PHASE_ITEMS);

      send_idle_pct = 65;
      recv_idle_pct = 27;
      run_random(PHASE_ITEMS);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(PHASE_ITEMS);
      fill_table();
      req_chan.valid <= 1'b0;

      @(posedge clock);
      while (expected_left != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d transactions (%0d clears) under three idling mixes and a full table",
               items_sent, clears_sent);
      $display("outcomes: %0d inserted, %0d present, %0d full, %0d cleared",
               inserted_seen, present_seen, full_seen, cleared_seen);
      if (fail_count == 0) begin
         $display("[generation_stamped_hash_set] OK");
      end else begin
         $display("[generation_stamped_hash_set] ERROR");
      end
      $finish;
   end

endmodule
